FILE: rtl/core/srrm_pkg.sv
// ----------------------------------------------------------------------------
// srrm_pkg
// Shared types and constants of the staged range remapper: request and
// result payloads, the stored table entry, the match result and the
// sequencer states.
// ----------------------------------------------------------------------------
package srrm_pkg;

  // default geometry of the remap tables
  localparam int STAGE_COUNT_DEF       = 7;
  localparam int ENTRIES_PER_STAGE_DEF = 64;

  localparam int WORD_W = 32;

  // request modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_MAP    = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  // result kinds
  localparam logic KIND_LOCATION = 1'b0;
  localparam logic KIND_MINIMUM  = 1'b1;

  // input request payload
  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        stage;
    logic [5:0]        slot;
    logic [WORD_W-1:0] dest_base;
    logic [WORD_W-1:0] source_base;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] value_in;
  } srrm_in_t;

  // result payload
  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] location;
    logic [WORD_W-1:0] minimum;
    logic              any_seen;
  } srrm_out_t;

  // one word of the table memory
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] dest_base;
    logic [WORD_W-1:0] source_base;
    logic [WORD_W-1:0] span;
  } srrm_entry_t;

  // outcome of testing one entry against a value
  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] value;
  } srrm_match_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_REPORT
  } srrm_state_t;

endpackage

FILE: rtl/core/srrm_ram.sv
// ----------------------------------------------------------------------------
// srrm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module srrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/srrm_match.sv
// ----------------------------------------------------------------------------
// srrm_match
// Tests one table entry against a value: hit when the entry is valid and
// the value lies in [source_base, source_base + span), with the range end
// formed in 33 bits. Also forms the remapped value modulo 2^32.
// ----------------------------------------------------------------------------
module srrm_match
  import srrm_pkg::*;
(
  input  srrm_entry_t       entry,
  input  logic [WORD_W-1:0] value,
  output srrm_match_t       res
);

  logic [WORD_W:0] lo;
  logic [WORD_W:0] hi;
  logic [WORD_W:0] val_ext;

  // range bounds without wrap
  assign lo      = {1'b0, entry.source_base};
  assign hi      = lo + {1'b0, entry.span};
  assign val_ext = {1'b0, value};

  // hit test and offset move
  assign res.hit   = entry.valid && (val_ext >= lo) && (val_ext < hi);
  assign res.value = value - entry.source_base + entry.dest_base;

endmodule

FILE: rtl/core/staged_range_remap_min_unit.sv
// ----------------------------------------------------------------------------
// staged_range_remap_min_unit
// Staged range remapper with running minimum, table held in one RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table RAM once to clear the valid marks,
// and accepts no request until that pass ends. A load request writes the
// table in the cycle it is accepted; a report request is accepted, then
// gives its result once the output register is free. A map request reads
// the table through the RAM's single read port, one entry a cycle: a stage
// ends at its first hit or after its last slot, and the location waits for a
// free output register. A new request is taken whenever the sequencer is
// idle, even while a result is still waiting in the output register.
// ----------------------------------------------------------------------------
module staged_range_remap_min_unit
  import srrm_pkg::*;
#(
  parameter int STAGE_COUNT       = STAGE_COUNT_DEF,
  parameter int ENTRIES_PER_STAGE = ENTRIES_PER_STAGE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  srrm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output srrm_out_t out_data
);

  localparam int TOTAL   = STAGE_COUNT * ENTRIES_PER_STAGE;
  localparam int AW      = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SW      = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
  localparam int KW      = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
  localparam int ENTRY_W = $bits(srrm_entry_t);

  srrm_state_t state_r, state_nxt;

  // scan counters
  logic [SW-1:0]     st_r, st_nxt;
  logic [KW-1:0]     sl_r, sl_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic              iss_en_r, iss_en_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic [WORD_W-1:0] value_r, value_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;

  // running minimum
  logic [WORD_W-1:0] min_r, min_nxt;
  logic              seen_r, seen_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  srrm_out_t out_data_r, out_data_nxt;

  // memory ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  srrm_entry_t       ram_wdata;
  logic              ram_re;
  srrm_entry_t       ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic          accept;
  logic          slot_free;
  logic          load_ok;
  logic [AW-1:0] load_addr;
  logic          clr_done;
  logic          resolve;
  logic          last_stage;
  logic [WORD_W-1:0] new_min;
  srrm_match_t   match;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // load address and range check
  assign load_ok   = (int'(in_data.stage) < STAGE_COUNT) &&
                     (int'(in_data.slot) < ENTRIES_PER_STAGE);
  assign load_addr = AW'(int'(in_data.stage) * ENTRIES_PER_STAGE + int'(in_data.slot));

  assign clr_done   = (clr_r == AW'(TOTAL - 1));
  assign last_stage = (st_r == SW'(STAGE_COUNT - 1));

  // table memory
  srrm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TOTAL)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = srrm_entry_t'(ram_rdata_raw);

  // entry test on the returned word
  srrm_match u_match (
    .entry (ram_rdata),
    .value (value_r),
    .res   (match)
  );

  // stage ends on the first hit or after its last slot
  assign resolve = (state_r == ST_SCAN) && rd_vld_r && (match.hit || rd_last_r);

  assign new_min = (value_r < min_r) ? value_r : min_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_MAP) begin
            state_nxt = ST_SCAN;
          end else if (in_data.mode == MODE_REPORT) begin
            state_nxt = ST_REPORT;
          end
        end
      end
      ST_SCAN: begin
        if (resolve && last_stage) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_REPORT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    st_nxt        = st_r;
    sl_nxt        = sl_r;
    addr_nxt      = addr_r;
    base_nxt      = base_r;
    iss_en_nxt    = iss_en_r;
    rd_vld_nxt    = 1'b0;
    rd_last_nxt   = rd_last_r;
    value_nxt     = value_r;
    clr_nxt       = clr_r;
    min_nxt       = min_r;
    seen_nxt      = seen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = load_addr;
    ram_wdata     = '{valid: 1'b1, dest_base: in_data.dest_base,
                      source_base: in_data.source_base, span: in_data.span};
    ram_re        = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        // sweep the valid marks to zero
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_LOAD) begin
            ram_we = load_ok;
          end else if (in_data.mode == MODE_MAP) begin
            st_nxt     = '0;
            sl_nxt     = '0;
            addr_nxt   = '0;
            base_nxt   = '0;
            iss_en_nxt = 1'b1;
            value_nxt  = in_data.value_in;
          end
        end
      end
      ST_SCAN: begin
        // issue one read a cycle within the current stage
        ram_re = iss_en_r;
        if (resolve) begin
          if (match.hit) value_nxt = match.value;
          st_nxt     = st_r + SW'(1);
          sl_nxt     = '0;
          base_nxt   = base_r + AW'(ENTRIES_PER_STAGE);
          addr_nxt   = base_r + AW'(ENTRIES_PER_STAGE);
          iss_en_nxt = !last_stage;
          rd_vld_nxt = 1'b0;
        end else if (iss_en_r) begin
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (sl_r == KW'(ENTRIES_PER_STAGE - 1));
          if (sl_r == KW'(ENTRIES_PER_STAGE - 1)) begin
            iss_en_nxt = 1'b0;
          end else begin
            sl_nxt   = sl_r + KW'(1);
            addr_nxt = addr_r + AW'(1);
          end
        end
      end
      ST_FINISH: begin
        // deliver location and fold it into the minimum
        if (slot_free) begin
          min_nxt       = new_min;
          seen_nxt      = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: KIND_LOCATION, location: value_r,
                            minimum: new_min, any_seen: 1'b1};
        end
      end
      ST_REPORT: begin
        // report the minimum and clear it
        if (slot_free) begin
          min_nxt       = '1;
          seen_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: KIND_MINIMUM, location: '0,
                            minimum: min_r, any_seen: seen_r};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      iss_en_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      min_r       <= '1;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      iss_en_r    <= iss_en_nxt;
      rd_vld_r    <= rd_vld_nxt;
      min_r       <= min_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    st_r       <= st_nxt;
    sl_r       <= sl_nxt;
    addr_r     <= addr_nxt;
    base_r     <= base_nxt;
    rd_last_r  <= rd_last_nxt;
    value_r    <= value_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
